/* rtl/client_slot_table_unit_macros.svh */
// Assertion macros for the client slot table unit.
`ifndef CLIENT_SLOT_TABLE_UNIT_MACROS_SVH
`define CLIENT_SLOT_TABLE_UNIT_MACROS_SVH
`define CST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/cst_pkg.sv */
// Package with request codes, status codes and the request record.
package cst_pkg;
	localparam logic [2:0] MODE_REG = 3'd0;
	localparam logic [2:0] MODE_UNREG = 3'd1;
	localparam logic [2:0] MODE_FSOCK = 3'd2;
	localparam logic [2:0] MODE_FADDR = 3'd3;
	localparam logic [2:0] MODE_NEXT = 3'd4;
	localparam logic [2:0] MODE_SHUT = 3'd5;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INUSE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;
	typedef struct packed {
		logic [2:0] mode;
		logic [15:0] sock;
		logic [3:0] slot;
		logic [63:0] addr_key;
		logic [4:0] addr_len;
		logic [63:0] name_key;
	} req_t;
endpackage

/* rtl/client_slot_table_unit.sv */
// Top level of the client slot table unit.
// With the back part free, an accepted request passes the queue registers and then the result
// register, which raises the result strobe; a shutdown gives one result per active slot, with
// a gap after each, as the back part waits while its single result register shows a result.
// A two-entry request queue holds off busy. Reset clears all active flags, the rotate pointer
// and the queue at once. Results cannot be stalled by the receiver.
`include "client_slot_table_unit_macros.svh"
module client_slot_table_unit import cst_pkg::*; #(
	parameter int SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] mode,
	input logic [15:0] sock,
	input logic [3:0] slot,
	input logic [63:0] addr_key,
	input logic [4:0] addr_len,
	input logic [63:0] name_key,
	output logic strobe,
	output logic [1:0] status,
	output logic [3:0] found_slot,
	output logic [15:0] sock_out,
	output logic [63:0] addr_out,
	output logic last
);
	req_t rq_in, rq;
	logic push, pop, full, avail, idle;
	assign rq_in = '{mode: mode, sock: sock, slot: slot, addr_key: addr_key,
		addr_len: addr_len, name_key: name_key};
	assign push = start && !busy;
	assign busy = full;
	cst_front u_front (.clk, .arst_n, .push, .req_in(rq_in), .pop, .full, .avail,
		.req_out(rq));
	cst_back #(.SLOTS(SLOTS)) u_back (.clk, .arst_n, .avail, .req(rq), .pop, .idle,
		.res_valid(strobe), .res_status(status), .res_slot(found_slot),
		.res_sock(sock_out), .res_addr(addr_out), .res_last(last));
	`CST_ASSERT_NXT(a_pop_strobe, pop, strobe && last)
	`CST_ASSERT_IMP(a_idle, idle, !strobe)
	`CST_ASSERT_NXT(a_gap, strobe, !strobe)
endmodule

/* rtl/cst_front.sv */
// Front part: accepts requests into a two-entry queue.
module cst_front import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input req_t req_in,
	input logic pop,
	output logic full,
	output logic avail,
	output req_t req_out
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign req_out = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= req_in;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/cst_back.sv */
// Back part: holds the table and carries out one request at a time, a shutdown one slot per result.
module cst_back import cst_pkg::*; #(
	parameter int SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input req_t req,
	output logic pop,
	output logic idle,
	output logic res_valid,
	output logic [1:0] res_status,
	output logic [3:0] res_slot,
	output logic [15:0] res_sock,
	output logic [63:0] res_addr,
	output logic res_last
);
	localparam int IW = $clog2(SLOTS);
	logic [SLOTS-1:0] act_q;
	logic [15:0] sock_q [SLOTS];
	logic [63:0] addr_q [SLOTS];
	logic [4:0] alen_q [SLOTS];
	logic [63:0] name_q [SLOTS];
	logic [IW-1:0] rot_q;
	logic [SLOTS-1:0] m_name, m_sock, m_addr, rr, rot_mask;
	logic [IW-1:0] i_name, i_sock, i_addr, i_free, i_rr, i_sh, i_lo, i_all;
	logic h_rr_hi;
	logic [IW-1:0] sel;
	logic [1:0] st;
	logic hit, unreg_ok;
	always_comb begin
		m_name = '0; m_sock = '0; m_addr = '0; rot_mask = '0;
		for (int i = 0; i < SLOTS; i++) begin
			m_name[i] = act_q[i] && name_q[i] == req.name_key;
			m_sock[i] = act_q[i] && sock_q[i] == req.sock;
			m_addr[i] = act_q[i] && alen_q[i] == req.addr_len && addr_q[i] == req.addr_key;
			rot_mask[i] = IW'(i) >= rot_q;
		end
		rr = act_q & rot_mask;
		h_rr_hi = |rr;
	end
	function automatic logic [IW-1:0] lowest(input logic [SLOTS-1:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) if (v[i]) r = IW'(i);
		return r;
	endfunction
	assign i_name = lowest(m_name);
	assign i_sock = lowest(m_sock);
	assign i_addr = lowest(m_addr);
	assign i_free = lowest(~act_q);
	assign i_lo = lowest(rr);
	assign i_all = lowest(act_q);
	assign i_rr = h_rr_hi ? i_lo : i_all;
	assign i_sh = i_all;
	assign unreg_ok = 32'(req.slot) < SLOTS && act_q[IW'(req.slot)];
	always_comb begin
		sel = '0; st = ST_NONE; hit = 1'b0;
		unique case (req.mode)
			MODE_REG: begin
				if (|m_name) begin sel = i_name; st = ST_INUSE; hit = 1'b1; end
				else if (~&act_q) begin sel = i_free; st = ST_OK; hit = 1'b1; end
				else st = ST_FULL;
			end
			MODE_UNREG: if (unreg_ok) begin sel = IW'(req.slot); st = ST_OK; hit = 1'b1; end
			MODE_FSOCK: if (|m_sock) begin sel = i_sock; st = ST_OK; hit = 1'b1; end
			MODE_FADDR: if (|m_addr) begin sel = i_addr; st = ST_OK; hit = 1'b1; end
			MODE_NEXT: if (|act_q) begin sel = i_rr; st = ST_OK; hit = 1'b1; end
			MODE_SHUT: if (|act_q) begin sel = i_sh; st = ST_OK; hit = 1'b1; end
			default: ;
		endcase
	end
	logic go, fin;
	assign go = avail && !res_valid;
	assign fin = req.mode != MODE_SHUT || !(|(act_q & ~(SLOTS'(1) << sel))) || !hit;
	assign pop = go && fin;
	assign idle = !avail && !res_valid;
	always_ff @(posedge clk) begin
		if (go && req.mode == MODE_REG && st == ST_OK) begin
			sock_q[sel] <= req.sock;
			addr_q[sel] <= req.addr_key;
			alen_q[sel] <= req.addr_len;
			name_q[sel] <= req.name_key;
		end
		if (go) begin
			res_status <= st;
			res_slot <= hit ? 4'(sel) : 4'd0;
			res_sock <= (hit && req.mode != MODE_REG) || st == ST_INUSE ? sock_q[sel]
				: (st == ST_OK ? req.sock : 16'd0);
			res_addr <= (hit && req.mode != MODE_REG) || st == ST_INUSE ? addr_q[sel]
				: (st == ST_OK ? req.addr_key : 64'd0);
			res_last <= fin;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			rot_q <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= go;
			if (go && hit) begin
				if (req.mode == MODE_REG && st == ST_OK) act_q[sel] <= 1'b1;
				if (req.mode == MODE_UNREG || req.mode == MODE_SHUT) act_q[sel] <= 1'b0;
				if (req.mode == MODE_NEXT)
					rot_q <= (32'(sel) + 1 >= SLOTS) ? '0 : sel + IW'(1);
			end
		end
	end
endmodule

/* bench/tb_client_slot_table_unit.sv */
// Self-checking testbench for the client slot table unit with a built-in table predictor.
module tb_client_slot_table_unit;
	import cst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0] status;
		logic [3:0] found_slot;
		logic [15:0] sock_out;
		logic [63:0] addr_out;
		logic last;
	} outcome_t;

	class slot_scoreboard;
		bit act[16];
		logic [15:0] socks[16];
		logic [63:0] addrs[16];
		logic [4:0] lens[16];
		logic [63:0] names[16];
		int rot;
		outcome_t pending[$];
		int errors;

		function void push(logic [1:0] st, int s, bit lst);
			outcome_t o;
			o.status = st;
			o.last = lst;
			if (s < 0) begin
				o.found_slot = '0;
				o.sock_out = '0;
				o.addr_out = '0;
			end else begin
				o.found_slot = s[3:0];
				o.sock_out = socks[s];
				o.addr_out = addrs[s];
			end
			pending.push_back(o);
		endfunction

		function int lowest(req_t r);
			for (int i = 0; i < 16; i++) begin
				if (act[i] && ((r.mode == MODE_FSOCK && socks[i] == r.sock) ||
					(r.mode == MODE_FADDR && lens[i] == r.addr_len &&
					addrs[i] == r.addr_key) || (r.mode == MODE_REG && names[i] == r.name_key)))
					return i;
			end
			return -1;
		endfunction

		function void note_request(req_t r);
			int hit;
			int n;
			int s;
			hit = -1;
			case (r.mode)
				MODE_REG: begin
					hit = lowest(r);
					if (hit >= 0) begin
						push(ST_INUSE, hit, 1);
						return;
					end
					for (int i = 0; i < 16; i++) begin
						if (!act[i]) begin
							act[i] = 1;
							socks[i] = r.sock;
							addrs[i] = r.addr_key;
							lens[i] = r.addr_len;
							names[i] = r.name_key;
							push(ST_OK, i, 1);
							return;
						end
					end
					push(ST_FULL, -1, 1);
				end
				MODE_UNREG: begin
					if (act[r.slot]) begin
						act[r.slot] = 0;
						push(ST_OK, r.slot, 1);
					end else begin
						push(ST_NONE, -1, 1);
					end
				end
				MODE_FSOCK, MODE_FADDR: begin
					hit = lowest(r);
					push(hit >= 0 ? ST_OK : ST_NONE, hit, 1);
				end
				MODE_NEXT: begin
					for (n = 0; n < 16; n++) begin
						s = (rot + n) % 16;
						if (act[s]) begin
							rot = (s + 1) % 16;
							push(ST_OK, s, 1);
							return;
						end
					end
					push(ST_NONE, -1, 1);
				end
				MODE_SHUT: begin
					for (int i = 0; i < 16; i++) begin
						if (act[i]) begin
							act[i] = 0;
							push(ST_OK, i, 0);
							hit = pending.size() - 1;
						end
					end
					if (hit < 0)
						push(ST_NONE, -1, 1);
					else
						pending[hit].last = 1;
				end
				default: push(ST_NONE, -1, 1);
			endcase
		endfunction

		function void check_result(outcome_t got);
			outcome_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d", $realtime, got.status,
					got.found_slot);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status || got.found_slot !== w.found_slot ||
				got.sock_out !== w.sock_out || got.addr_out !== w.addr_out ||
				got.last !== w.last) begin
				$display("%0t: mismatch expected %0d/%0d/%h/%h/%0d actual %0d/%0d/%h/%h/%0d",
					$realtime, w.status, w.found_slot, w.sock_out, w.addr_out, w.last,
					got.status, got.found_slot, got.sock_out, got.addr_out, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, strobe, last;
	logic [2:0] mode;
	logic [15:0] sock, sock_out;
	logic [3:0] slot, found_slot;
	logic [63:0] addr_key, name_key, addr_out;
	logic [4:0] addr_len;
	logic [1:0] status;
	int gap_pct;
	slot_scoreboard table_sb;
	logic [63:0] name_pool[6];
	logic [63:0] addr_pool[4];
	logic [15:0] sock_pool[4];

	client_slot_table_unit u_top (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[client_slot_table_unit] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && strobe) begin
			o.status = status;
			o.found_slot = found_slot;
			o.sock_out = sock_out;
			o.addr_out = addr_out;
			o.last = last;
			table_sb.check_result(o);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send(req_t r);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		mode <= r.mode;
		sock <= r.sock;
		slot <= r.slot;
		addr_key <= r.addr_key;
		addr_len <= r.addr_len;
		name_key <= r.name_key;
		@(posedge clk);
		while (busy) @(posedge clk);
		table_sb.note_request(r);
		@(negedge clk);
	endtask

	function automatic req_t mk(logic [2:0] m);
		req_t r;
		r.mode = m;
		r.sock = sock_pool[$urandom_range(3)];
		r.slot = 4'($urandom_range(15));
		r.addr_key = addr_pool[$urandom_range(3)];
		r.addr_len = 5'($urandom_range(16));
		r.name_key = name_pool[$urandom_range(5)];
		if ($urandom_range(3) == 0) begin
			r.sock = 16'($urandom());
			r.addr_key = rand64();
			r.addr_len = 5'($urandom_range(31));
			r.name_key = rand64();
		end
		return r;
	endfunction

	initial begin
		req_t r;
		int pick;
		table_sb = new();
		start = 0;
		mode = '0;
		sock = '0;
		slot = '0;
		addr_key = '0;
		addr_len = '0;
		name_key = '0;
		gap_pct = 0;
		for (int i = 0; i < 4; i++) begin
			sock_pool[i] = 16'($urandom());
			addr_pool[i] = rand64();
		end
		sock_pool[0] = '1;
		addr_pool[0] = '1;
		for (int i = 0; i < 6; i++) name_pool[i] = rand64();
		name_pool[0] = '0;
		name_pool[1] = '1;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: empty-table misses, fill to full, name clash, extremes.
		r = mk(MODE_SHUT);
		send(r);
		r = mk(MODE_NEXT);
		send(r);
		r = mk(MODE_UNREG);
		send(r);
		for (int i = 0; i < 17; i++) begin
			r = mk(MODE_REG);
			r.name_key = (i == 0) ? '1 : 64'(i);
			r.sock = (i == 0) ? '1 : 16'(i);
			r.addr_key = (i == 0) ? '1 : 64'(i);
			r.addr_len = (i == 0) ? 5'd16 : 5'(i % 17);
			send(r);
		end
		r.mode = MODE_UNREG;
		r.slot = 4'd15;
		send(r);
		r.mode = MODE_REG;
		r.name_key = '1;
		send(r);
		r.mode = MODE_FSOCK;
		r.sock = '1;
		send(r);
		r.mode = MODE_FADDR;
		r.addr_key = '1;
		r.addr_len = 5'd16;
		send(r);
		r.mode = MODE_NEXT;
		send(r);
		r.mode = 3'd6;
		send(r);
		r.mode = 3'd7;
		send(r);
		r.mode = MODE_SHUT;
		send(r);

		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 37 : (ph == 1) ? 51 : 0;
			for (int k = 0; k < 85; k++) begin
				pick = $urandom_range(99);
				if (pick < 35) r = mk(MODE_REG);
				else if (pick < 50) r = mk(MODE_UNREG);
				else if (pick < 62) r = mk(MODE_FSOCK);
				else if (pick < 74) r = mk(MODE_FADDR);
				else if (pick < 90) r = mk(MODE_NEXT);
				else if (pick < 95) r = mk(MODE_SHUT);
				else r = mk(3'($urandom_range(7)));
				send(r);
			end
		end
		start <= 0;

		while (table_sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (table_sb.errors == 0)
			$display("[client_slot_table_unit] OK");
		else
			$display("[client_slot_table_unit] ERROR");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/client_slot_table_unit.sv
bench/tb_client_slot_table_unit.sv
